// ===== src/debug_packet_argument_decoder_unit_assert.svh =====
// Assertion macros for the debug packet argument decoder.
// Needs a clock named clock and a reset named reset in the including module.
`ifndef DEBUG_PACKET_ARGUMENT_DECODER_UNIT_ASSERT_SVH
`define DEBUG_PACKET_ARGUMENT_DECODER_UNIT_ASSERT_SVH

// same-cycle implication
`define DPAD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dpad assertion failed");

// next-cycle implication
`define DPAD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dpad assertion failed");

`endif

// ===== src/dpad_pkg.sv =====
// Shared types, codes and the hex digit decoder of the debug packet argument decoder.
// No dependencies.
`default_nettype none
package dpad_pkg;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] ch;
   } dpad_req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data_byte;
      logic [1:0]  status;
      logic [63:0] first_value;
      logic [31:0] second_value;
      logic [2:0]  bp_type;
   } dpad_rsp_type;

   typedef struct packed {
      logic         valid;
      dpad_rsp_type rsp;
   } dpad_result_type;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_BPSKIP  = 4'd1,
      PH_BPTYPE  = 4'd2,
      PH_BPCOMMA = 4'd3,
      PH_ADDR    = 4'd4,
      PH_LEN     = 4'd5,
      PH_REG     = 4'd6,
      PH_REGEQ   = 4'd7,
      PH_DATA    = 4'd8
   } dpad_phase_type;

   localparam logic [2:0] MODE_ADDR_LEN = 3'd0;
   localparam logic [2:0] MODE_BREAK    = 3'd1;
   localparam logic [2:0] MODE_REG      = 3'd2;
   localparam logic [2:0] MODE_REG_DATA = 3'd3;
   localparam logic [2:0] MODE_DATA     = 3'd4;

   localparam logic       KIND_BYTE    = 1'b0;
   localparam logic       KIND_SUMMARY = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_ODD   = 2'd1;
   localparam logic [1:0] STATUS_ERROR = 2'd2;

   localparam logic [7:0] CHAR_END   = 8'h00;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_EQUAL = 8'h3D;

   localparam logic [4:0] BP_TYPE_LAST = 5'd4;
   localparam int         COUNT_W      = 5;

   // bit 4 set marks a non-hex character
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
      else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h41 + 8'd10);
      else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h61 + 8'd10);
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== src/dpad_parser.sv =====
// String state and single-pass decode of one registered request.
// Depends on dpad_pkg.
`default_nettype none
module dpad_parser #(
   parameter int ADDR_DIGITS = 16,
   parameter int LEN_DIGITS  = 8
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       go,
   input  dpad_pkg::dpad_req_type    req,
   output dpad_pkg::dpad_result_type result
);
   import dpad_pkg::*;

   localparam logic [COUNT_W-1:0] AddrLimit = COUNT_W'(ADDR_DIGITS);
   localparam logic [COUNT_W-1:0] LenLimit  = COUNT_W'(LEN_DIGITS);

   dpad_phase_type     phase_ff, phase_in;
   logic [2:0]         mode_ff, mode_in;
   logic [63:0]        acc_ff, acc_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [63:0]        sfirst_ff, sfirst_in;
   logic [2:0]         stype_ff, stype_in;
   logic               half_ff, half_in;
   logic [4:0]         held_ff, held_in;
   logic               err_ff, err_in;
   logic [4:0]         nib;
   logic               take_addr;
   logic               take_len;

   assign nib = hex_value(req.ch);

   always_comb begin
      phase_in  = phase_ff;
      mode_in   = mode_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      sfirst_in = sfirst_ff;
      stype_in  = stype_ff;
      half_in   = half_ff;
      held_in   = held_ff;
      err_in    = err_ff;
      result    = '0;

      if (phase_ff == PH_IDLE) begin
         mode_in   = req.mode;
         acc_in    = '0;
         cnt_in    = '0;
         sfirst_in = '0;
         stype_in  = '0;
         half_in   = 1'b0;
         held_in   = '0;
         err_in    = 1'b0;
         unique case (req.mode)
            MODE_ADDR_LEN: phase_in = PH_ADDR;
            MODE_BREAK:    phase_in = PH_BPSKIP;
            MODE_REG:      phase_in = PH_REG;
            MODE_REG_DATA: phase_in = PH_REGEQ;
            MODE_DATA:     phase_in = PH_DATA;
            default: begin
               phase_in = PH_DATA;
               err_in   = 1'b1;
            end
         endcase
      end

      take_addr = !nib[4] && (cnt_in < AddrLimit);
      take_len  = !nib[4] && (cnt_in < LenLimit);

      if (req.ch != CHAR_END) begin
         if (!err_in) begin
            unique case (phase_in)
               PH_BPSKIP: phase_in = PH_BPTYPE;
               PH_BPTYPE: begin
                  if (nib > BP_TYPE_LAST) err_in = 1'b1;
                  else begin
                     stype_in = nib[2:0];
                     phase_in = PH_BPCOMMA;
                  end
               end
               PH_BPCOMMA: begin
                  if (req.ch == CHAR_COMMA) begin
                     phase_in = PH_ADDR;
                     acc_in   = '0;
                     cnt_in   = '0;
                  end else err_in = 1'b1;
               end
               PH_ADDR: begin
                  if (take_addr) begin
                     acc_in = {acc_in[59:0], nib[3:0]};
                     cnt_in = cnt_in + COUNT_W'(1);
                  end else if (req.ch == CHAR_COMMA) begin
                     sfirst_in = acc_in;
                     phase_in  = PH_LEN;
                     acc_in    = '0;
                     cnt_in    = '0;
                  end else err_in = 1'b1;
               end
               PH_LEN, PH_REG: begin
                  if (take_len) begin
                     acc_in = {acc_in[59:0], nib[3:0]};
                     cnt_in = cnt_in + COUNT_W'(1);
                  end else err_in = 1'b1;
               end
               PH_REGEQ: begin
                  if (take_len) begin
                     acc_in = {acc_in[59:0], nib[3:0]};
                     cnt_in = cnt_in + COUNT_W'(1);
                  end else if (req.ch == CHAR_EQUAL) begin
                     sfirst_in = acc_in;
                     phase_in  = PH_DATA;
                  end else err_in = 1'b1;
               end
               PH_DATA: begin
                  if (!half_in) begin
                     held_in = nib;
                     half_in = 1'b1;
                  end else begin
                     half_in = 1'b0;
                     if (held_in[4] || nib[4]) err_in = 1'b1;
                     else begin
                        result.valid         = 1'b1;
                        result.rsp.kind      = KIND_BYTE;
                        result.rsp.data_byte = {held_in[3:0], nib[3:0]};
                     end
                  end
               end
               default: err_in = 1'b1;
            endcase
         end
      end else begin
         result.valid    = 1'b1;
         result.rsp.kind = KIND_SUMMARY;
         if (!err_in) begin
            unique case (phase_in)
               PH_LEN: begin
                  if (cnt_in == '0) err_in = 1'b1;
                  else begin
                     result.rsp.first_value  = sfirst_in;
                     result.rsp.second_value = acc_in[31:0];
                     result.rsp.bp_type      = stype_in;
                  end
               end
               PH_REG: begin
                  if (cnt_in == '0) err_in = 1'b1;
                  else result.rsp.first_value = acc_in;
               end
               PH_DATA: begin
                  result.rsp.status      = half_in ? STATUS_ODD : STATUS_OK;
                  result.rsp.first_value = sfirst_in;
               end
               default: err_in = 1'b1;
            endcase
         end
         if (err_in) begin
            result.rsp.status       = STATUS_ERROR;
            result.rsp.first_value  = '0;
            result.rsp.second_value = '0;
            result.rsp.bp_type      = '0;
         end
         phase_in  = PH_IDLE;
         acc_in    = '0;
         cnt_in    = '0;
         sfirst_in = '0;
         stype_in  = '0;
         half_in   = 1'b0;
         held_in   = '0;
         err_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         mode_ff   <= '0;
         acc_ff    <= '0;
         cnt_ff    <= '0;
         sfirst_ff <= '0;
         stype_ff  <= '0;
         half_ff   <= 1'b0;
         held_ff   <= '0;
         err_ff    <= 1'b0;
      end else if (go) begin
         phase_ff  <= phase_in;
         mode_ff   <= mode_in;
         acc_ff    <= acc_in;
         cnt_ff    <= cnt_in;
         sfirst_ff <= sfirst_in;
         stype_ff  <= stype_in;
         half_ff   <= half_in;
         held_ff   <= held_in;
         err_ff    <= err_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/dpad_rsp_reg.sv =====
// Result register of the debug packet argument decoder.
// Depends on dpad_pkg.
`default_nettype none
module dpad_rsp_reg (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    load,
   input  dpad_pkg::dpad_rsp_type load_data,
   output logic                   ready,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output dpad_pkg::dpad_rsp_type rsp_data
);
   import dpad_pkg::*;

   logic         vld_ff, vld_in;
   dpad_rsp_type data_ff;

   assign ready     = !vld_ff || !rsp_stall;
   assign vld_in    = ready ? load : vld_ff;
   assign rsp_valid = vld_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else vld_ff <= vld_in;
   end

   always_ff @(posedge clock) begin
      if (ready && load) data_ff <= load_data;
   end

endmodule
`default_nettype wire

// ===== src/debug_packet_argument_decoder_unit.sv =====
// Top level of the debug packet argument decoder: request register, parser, result register.
// Depends on dpad_pkg, dpad_parser, dpad_rsp_reg and the assertion macro header.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  mode, ch
//   rsp      out        rsp_valid / rsp_stall  kind, data_byte, status, values, bp_type
//
// One request per cycle unless req_stall is high; a request waits in the request register.
// The decode of the registered request into state and result is combinational.
// Reset clears the string state; the decoder waits for the first character of a string.
// A stall on rsp while a result is held holds the request register, which then stalls req.
`default_nettype none
module debug_packet_argument_decoder_unit #(
   parameter int ADDR_DIGITS = 16,
   parameter int LEN_DIGITS  = 8
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  dpad_pkg::dpad_req_type req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output dpad_pkg::dpad_rsp_type rsp_data
);
   import dpad_pkg::*;

   logic            in_vld_ff, in_vld_in;
   dpad_req_type    in_req_ff;
   logic            out_ready;
   logic            adv;
   dpad_result_type result;

   assign adv       = in_vld_ff && out_ready;
   assign req_stall = in_vld_ff && !out_ready;
   assign in_vld_in = req_stall ? in_vld_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) in_vld_ff <= 1'b0;
      else in_vld_ff <= in_vld_in;
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) in_req_ff <= req_data;
   end

   dpad_parser #(
      .ADDR_DIGITS(ADDR_DIGITS),
      .LEN_DIGITS (LEN_DIGITS)
   ) u_parser (
      .clock (clock),
      .reset (reset),
      .go    (adv),
      .req   (in_req_ff),
      .result(result)
   );

   dpad_rsp_reg u_rsp_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (adv && result.valid),
      .load_data(result.rsp),
      .ready    (out_ready),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

`include "debug_packet_argument_decoder_unit_assert.svh"

   `DPAD_ASSERT_NOW(a_stall_needs_request, req_stall, in_vld_ff)
   `DPAD_ASSERT_NEXT(a_held_request_kept, in_vld_ff && !adv, in_vld_ff)
   `DPAD_ASSERT_NOW(a_result_from_advance, $rose(rsp_valid), $past(adv))
   `DPAD_ASSERT_NOW(a_error_clears_values,
      rsp_valid && rsp_data.kind == KIND_SUMMARY && rsp_data.status == STATUS_ERROR,
      rsp_data.first_value == '0 && rsp_data.second_value == '0 && rsp_data.bp_type == '0)

endmodule
`default_nettype wire
